>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is low.
`define VPBC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vpbc check failed");

// Check a property on every rising clock edge, reset included.
`define VPBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("vpbc check failed");

`endif

>>> hw/rtl/vpbc_pkg.sv
// Types, constants and tables of the video port and beam counter.
`timescale 1ns / 1ps
`default_nettype none
package vpbc_pkg;

  localparam int unsigned VramAw    = 14;
  localparam int unsigned CramAw    = 5;
  localparam int unsigned LineLen   = 342;
  localparam int unsigned ColTabN   = LineLen - 256;
  localparam int unsigned NumRegs   = 11;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_POLL  = 2'd3
  } mode_e;

  localparam logic [1:0] CODE_VRAM_RD = 2'd0;
  localparam logic [1:0] CODE_VRAM_WR = 2'd1;
  localparam logic [1:0] CODE_REG     = 2'd2;
  localparam logic [1:0] CODE_CRAM    = 2'd3;

  localparam logic [1:0] HGT_192 = 2'd0;
  localparam logic [1:0] HGT_224 = 2'd1;
  localparam logic [1:0] HGT_240 = 2'd2;

  typedef logic [7:0] reg_file_t [NumRegs];

  localparam reg_file_t REG_RESET = '{
    8'h36, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'h00, 8'h00, 8'h00, 8'hFF
  };

  typedef struct packed {
    logic              vram_we;
    logic              cram_we;
    logic [VramAw-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef logic [7:0] col_tab_t [ColTabN];

  function automatic col_tab_t build_col_tab();
    col_tab_t    t;
    int unsigned c;
    int unsigned v;
    for (int unsigned k = 0; k < ColTabN; k++) begin
      c = k + 256;
      if (c < 271)      v = 8'h80 + ((c - 256) * 7) / 14;
      else if (c < 279) v = 8'h87 + ((c - 271) * 4) / 7;
      else if (c < 305) v = 8'h8B + ((c - 279) * 8'h62) / 25;
      else if (c < 307) v = 8'hED + (c - 305);
      else if (c < 321) v = 8'hEE + ((c - 307) * 7) / 13;
      else if (c < 329) v = 8'hF5 + ((c - 321) * 4) / 7;
      else              v = 8'hF9 + ((c - 329) * 6) / 12;
      t[k] = v[7:0];
    end
    return t;
  endfunction

  localparam col_tab_t COL_TAB = build_col_tab();

endpackage
`default_nettype wire

>>> hw/rtl/video_port_and_beam_counter.sv
// Top level: CPU port decode, beam counter and sequencer of the video port block.
//
// Input transactions arrive on s_axis: tuser carries the mode (pixel tick, port read,
// port write, interrupt poll), tdata the port number and the write byte. Every input
// transaction gives exactly one result on m_axis: read byte, frame sync, interrupt
// seen and bad port flags. cfg_we_i/cfg_wdata_i set the NTSC (1) or PAL (0) standard.
// Ticks, polls, writes and counter or status reads put their result straight into the
// output register; data port reads and the prefetch that follows a VRAM read setup
// pass through ST_MEMRD for the registered read of the video RAM; a tick that reaches
// the line interrupt column with line interrupts on and a nonzero reload waits in
// ST_DIV for the bit-serial remainder unit.
// One item is in flight at a time; the next is taken once its result is registered.
// After reset the block sweeps video and palette RAM to zero, one entry per cycle,
// over 16384 addresses with s_axis_tready low; configuration writes are taken meanwhile.
// When the receiver stalls the result holds in the output register and s_axis_tready
// stays low until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module video_port_and_beam_counter
  import vpbc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,     // ntsc_standard
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,    // port[7:0], data[15:8]
  input  wire logic [1:0]  s_axis_tuser,    // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata     // read_data, frame_sync, interrupt_seen,
                                            // bad_port, zero fill
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MEMRD = 4'b0100,
    ST_DIV   = 4'b1000
  } state_e;

  typedef struct packed {
    logic       bad;
    logic       seen;
    logic       fs;
    logic [7:0] rd;
  } res_t;

  state_e            state_q, state_d;
  logic [VramAw-1:0] clr_q, clr_d;
  logic              ntsc_q;
  reg_file_t         regs_q, regs_d;
  logic [VramAw-1:0] addr_q, addr_d;
  logic              second_q, second_d;
  logic [1:0]        code_q, code_d;
  logic [7:0]        prefetch_q, prefetch_d;
  logic [7:0]        status_q, status_d;
  logic [8:0]        col_q, col_d;
  logic [8:0]        line_q, line_d;
  logic              irq_q, irq_d;
  logic [1:0]        height_q, height_d;
  logic              pf_only_q, pf_only_d;
  logic              out_vld_q, out_vld_d;
  res_t              out_q, out_d;

  mem_req_t          mem_req;
  logic [7:0]        vram_rdata, cram_rdata;
  logic              rem_start, rem_done, rem_zero;

  mode_e             mode;
  logic [7:0]        port, wbyte;
  logic              port_ctr, port_vdp;
  logic [8:0]        frame_len, frame_irq_line, vs_line;
  logic [9:0]        col_inc, line_inc;
  logic [8:0]        col_nxt, line_nxt, line_dist, divisor;
  logic [8:0]        cc;
  logic [7:0]        col_cnt, line_cnt;
  logic [7:0]        r0, r1;
  logic [VramAw-1:0] new_addr;
  logic [3:0]        reg_num;
  res_t              res;
  logic              done;

  assign mode   = mode_e'(s_axis_tuser);
  assign port   = s_axis_tdata[7:0];
  assign wbyte  = s_axis_tdata[15:8];
  assign port_ctr = (port[7:6] == 2'b01);
  assign port_vdp = (port[7:6] == 2'b10);

  assign frame_len      = ntsc_q ? 9'd262 : 9'd313;
  assign frame_irq_line = ntsc_q ? 9'd219 : 9'd270;

  always_comb begin
    unique case (height_q)
      HGT_224: vs_line = ntsc_q ? 9'd235 : 9'd281;
      HGT_240: vs_line = ntsc_q ? 9'd240 : 9'd297;
      default: vs_line = ntsc_q ? 9'd219 : 9'd249;
    endcase
  end

  always_comb begin
    col_inc  = {1'b0, col_q} + 10'd1;
    line_inc = {1'b0, line_q} + 10'd1;
    if (col_inc >= 10'(LineLen)) begin
      col_nxt  = '0;
      line_nxt = (line_inc >= {1'b0, frame_len}) ? 9'd0 : line_inc[8:0];
    end else begin
      col_nxt  = col_inc[8:0];
      line_nxt = line_q;
    end
    line_dist = (line_nxt >= 9'd3) ? 9'(line_nxt - 9'd3) : 9'(9'd3 - line_nxt);
    divisor   = {1'b0, regs_q[10]} + 9'd1;
  end

  always_comb begin
    cc = (col_q > 9'(LineLen - 1)) ? 9'(LineLen - 1) : col_q;
    if (!cc[8]) begin
      col_cnt = cc[8:1] - {7'd0, (!cc[0] && (cc != '0))};
    end else begin
      col_cnt = COL_TAB[7'(cc - 9'd256)];
    end
  end

  always_comb begin
    if (ntsc_q) begin
      unique case (height_q)
        HGT_224: line_cnt = (line_q <= 9'hEA) ? line_q[7:0] : 8'(line_q - 9'd6);
        HGT_240: line_cnt = line_q[7:0];
        default: line_cnt = (line_q <= 9'hDA) ? line_q[7:0] : 8'(line_q - 9'd6);
      endcase
    end else begin
      unique case (height_q)
        HGT_224: line_cnt = (line_q <= 9'h102) ? line_q[7:0] : 8'(line_q - 9'h39);
        HGT_240: line_cnt = (line_q <= 9'h10A) ? line_q[7:0] : 8'(line_q - 9'h39);
        default: line_cnt = (line_q <= 9'hF2) ? line_q[7:0] : 8'(line_q - 9'h39);
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    regs_d     = regs_q;
    addr_d     = addr_q;
    second_d   = second_q;
    code_d     = code_q;
    prefetch_d = prefetch_q;
    status_d   = status_q;
    col_d      = col_q;
    line_d     = line_q;
    irq_d      = irq_q;
    height_d   = height_q;
    pf_only_d  = pf_only_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_d      = out_q;
    mem_req    = '0;
    mem_req.addr = addr_q;
    rem_start  = 1'b0;
    s_axis_tready = 1'b0;
    res        = '0;
    done       = 1'b0;
    new_addr   = {wbyte[5:0], addr_q[7:0]};
    reg_num    = wbyte[3:0];
    r0         = (reg_num == 4'd0) ? addr_q[7:0] : regs_q[0];
    r1         = (reg_num == 4'd1) ? addr_q[7:0] : regs_q[1];

    unique case (state_q)
      ST_CLEAR: begin
        mem_req.vram_we = 1'b1;
        mem_req.cram_we = 1'b1;
        mem_req.addr    = clr_q;
        clr_d           = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = !out_vld_q || m_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
          done = 1'b1;
          unique case (mode)
            MODE_TICK: begin
              col_d  = col_nxt;
              line_d = line_nxt;
              if (col_nxt == 9'd271) begin
                if (line_nxt == frame_irq_line) irq_d = 1'b1;
                if (regs_q[0][4]) begin
                  if (regs_q[10] == '0) begin
                    irq_d = 1'b1;
                  end else begin
                    rem_start = 1'b1;
                    done      = 1'b0;
                    state_d   = ST_DIV;
                  end
                end
              end
              if (col_nxt == 9'd279 && line_nxt == vs_line) begin
                status_d[7] = 1'b1;
                res.fs      = 1'b1;
              end
            end
            MODE_READ: begin
              if (port_ctr) begin
                res.rd = port[0] ? col_cnt : line_cnt;
              end else if (port_vdp) begin
                if (!port[0]) begin
                  addr_d    = addr_q + 1'b1;
                  pf_only_d = 1'b0;
                  done      = 1'b0;
                  state_d   = ST_MEMRD;
                end else begin
                  res.rd   = status_q;
                  status_d = status_q & 8'h1F;
                end
              end else begin
                res.bad = 1'b1;
              end
            end
            MODE_WRITE: begin
              if (port_vdp) begin
                if (!port[0]) begin
                  mem_req.wdata = wbyte;
                  if (code_q == CODE_CRAM) begin
                    mem_req.cram_we = 1'b1;
                  end else begin
                    mem_req.vram_we = 1'b1;
                    prefetch_d      = wbyte;
                  end
                  addr_d = addr_q + 1'b1;
                end else if (!second_q) begin
                  second_d = 1'b1;
                  addr_d   = {addr_q[VramAw-1:8], wbyte};
                end else begin
                  second_d = 1'b0;
                  addr_d   = new_addr;
                  code_d   = wbyte[7:6];
                  if (wbyte[7:6] == CODE_VRAM_RD) begin
                    mem_req.addr = new_addr;
                    addr_d       = new_addr + 1'b1;
                    pf_only_d    = 1'b1;
                    done         = 1'b0;
                    state_d      = ST_MEMRD;
                  end else if (wbyte[7:6] == CODE_REG && reg_num < 4'(NumRegs)) begin
                    regs_d[reg_num] = addr_q[7:0];
                    if (r0[2]) begin
                      if (r0[1] && r1[4])      height_d = HGT_224;
                      else if (r0[1] && r1[3]) height_d = HGT_240;
                      else                     height_d = HGT_192;
                    end
                  end
                end
              end
            end
            MODE_POLL: begin
              res.seen = irq_q;
              irq_d    = 1'b0;
            end
            default: ;
          endcase
          if (done) begin
            out_vld_d = 1'b1;
            out_d     = res;
          end
        end
      end
      ST_MEMRD: begin
        if (pf_only_q) begin
          prefetch_d = vram_rdata;
        end else if (code_q == CODE_VRAM_RD) begin
          res.rd     = prefetch_q;
          prefetch_d = vram_rdata;
        end else if (code_q == CODE_CRAM) begin
          res.rd = cram_rdata;
        end else begin
          res.rd = vram_rdata;
        end
        out_vld_d = 1'b1;
        out_d     = res;
        state_d   = ST_IDLE;
      end
      ST_DIV: begin
        if (rem_done) begin
          if (rem_zero) irq_d = 1'b1;
          out_vld_d = 1'b1;
          out_d     = res;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  vpbc_mem u_mem (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .vram_rdata_o (vram_rdata),
    .cram_rdata_o (cram_rdata)
  );

  vpbc_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (line_dist),
    .divisor_i  (divisor),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      ntsc_q     <= 1'b1;
      regs_q     <= REG_RESET;
      addr_q     <= '0;
      second_q   <= 1'b0;
      code_q     <= CODE_CRAM;
      prefetch_q <= '0;
      status_q   <= 8'h1F;
      col_q      <= '0;
      line_q     <= '0;
      irq_q      <= 1'b0;
      height_q   <= HGT_192;
      pf_only_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      if (cfg_we_i) ntsc_q <= cfg_wdata_i;
      regs_q     <= regs_d;
      addr_q     <= addr_d;
      second_q   <= second_d;
      code_q     <= code_d;
      prefetch_q <= prefetch_d;
      status_q   <= status_d;
      col_q      <= col_d;
      line_q     <= line_d;
      irq_q      <= irq_d;
      height_q   <= height_d;
      pf_only_q  <= pf_only_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q};

endmodule
`default_nettype wire

>>> hw/rtl/vpbc_mem.sv
// Video RAM and palette RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module vpbc_mem
  import vpbc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output logic [7:0]    vram_rdata_o,
  output logic [7:0]    cram_rdata_o
);

  logic [7:0] vram [2**VramAw];
  logic [7:0] cram [2**CramAw];

  always_ff @(posedge clk_i) begin
    if (req_i.vram_we) begin
      vram[req_i.addr] <= req_i.wdata;
    end
    vram_rdata_o <= vram[req_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cram_we) begin
      cram[req_i.addr[CramAw-1:0]] <= req_i.wdata;
    end
    cram_rdata_o <= cram[req_i.addr[CramAw-1:0]];
  end

endmodule
`default_nettype wire

>>> hw/rtl/vpbc_rem.sv
// Bit-serial remainder unit for the line interrupt divisibility test.
`timescale 1ns / 1ps
`default_nettype none
module vpbc_rem
  import vpbc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [8:0] dividend_i,
  input  wire logic [8:0] divisor_i,
  output logic            done_o,
  output logic            zero_o
);

  localparam logic [3:0] LastStep = 4'd8;

  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [8:0] rem_q, rem_d;
  logic [8:0] dvd_q, dvd_d;
  logic [8:0] dvs_q, dvs_d;
  logic [9:0] trial;

  always_comb begin
    trial  = {rem_q, dvd_q[8]};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 9'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[8:0];
      end
      dvd_d = {dvd_q[7:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == LastStep);
  assign zero_o = (rem_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

endmodule
`default_nettype wire

>>> hw/rtl/vpbc_checker.sv
// Port-level checker of the video port block and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vpbc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  `VPBC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `VPBC_ASSERT(a_one_in_flight, clk_i, rst_ni, s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
  `VPBC_ASSERT(a_fill_zero, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[15:11] == 5'd0))
  `VPBC_ASSERT(a_flags_excl, clk_i, rst_ni, m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
  `VPBC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid && !s_axis_tready)

endmodule

bind video_port_and_beam_counter vpbc_checker u_vpbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_video_port_and_beam_counter.sv
// Testbench: video port and beam counter checked against a cycle-free port and beam predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_video_port_and_beam_counter
  import vpbc_pkg::*;
();

  typedef struct {
    mode_e      mode;
    logic [7:0] port;
    logic [7:0] data;
    int         gap;
  } port_item_t;

  typedef struct packed {
    logic       bad_port;
    logic       irq_seen;
    logic       fsync;
    logic [7:0] rdata;
  } port_result_t;

  localparam logic [7:0] PORT_VCNT = 8'h7E;
  localparam logic [7:0] PORT_HCNT = 8'h7F;
  localparam logic [7:0] PORT_DATA = 8'hBE;
  localparam logic [7:0] PORT_CTRL = 8'hBF;
  localparam int VRAM_DEPTH_TB = 16384;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  video_port_and_beam_counter dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // beam and port predictor state
  logic [7:0]  vram_img [VRAM_DEPTH_TB];
  logic [7:0]  cram_img [32];
  logic [7:0]  regs_img [NumRegs];
  logic        ntsc_img = 1'b1;
  logic [13:0] addr_img = '0;
  logic        second_img = 1'b0;
  logic [1:0]  code_img = CODE_CRAM;
  logic [7:0]  prefetch_img = '0;
  logic [7:0]  status_img = 8'h1F;
  int unsigned col_img = 0;
  int unsigned line_img = 0;
  logic        irq_img = 1'b0;
  logic [1:0]  height_img = HGT_192;

  port_item_t   item_q[$];
  port_result_t result_q[$];
  port_item_t   cur_item;
  int           wait_cnt = 0;
  int           stall_cnt = 0;
  int           n_accepted = 0;
  int           n_errors = 0;
  logic         calm = 1'b0;
  logic         hold = 1'b0;

  function automatic int unsigned frame_len();
    return ntsc_img ? 262 : 313;
  endfunction

  function automatic void update_height();
    if (regs_img[0][2]) begin
      if (regs_img[0][1] && regs_img[1][4]) height_img = HGT_224;
      else if (regs_img[0][1] && regs_img[1][3]) height_img = HGT_240;
      else height_img = HGT_192;
    end
  endfunction

  function automatic logic [7:0] vcount_of();
    int unsigned i, v;
    i = line_img;
    if (ntsc_img) begin
      if (height_img == HGT_224) v = (i <= 'hEA) ? i : i - 6;
      else if (height_img == HGT_240) v = (i <= 'hFF) ? i : i - 'h100;
      else v = (i <= 'hDA) ? i : i - 6;
    end else begin
      if (height_img == HGT_224)
        v = (i <= 'hFF) ? i : ((i <= 'h102) ? i - 'h100 : i - 'h39);
      else if (height_img == HGT_240)
        v = (i <= 'hFF) ? i : ((i <= 'h10A) ? i - 'h100 : i - 'h39);
      else v = (i <= 'hF2) ? i : i - 'h39;
    end
    return v[7:0];
  endfunction

  function automatic logic [7:0] hcount_of();
    int unsigned c, v;
    c = (col_img > 341) ? 341 : col_img;
    if (c < 256)      v = (c * 127) / 255;
    else if (c < 271) v = 'h80 + ((c - 256) * 7) / 14;
    else if (c < 279) v = 'h87 + ((c - 271) * 4) / 7;
    else if (c < 305) v = 'h8B + ((c - 279) * 'h62) / 25;
    else if (c < 307) v = 'hED + (c - 305);
    else if (c < 321) v = 'hEE + ((c - 307) * 7) / 13;
    else if (c < 329) v = 'hF5 + ((c - 321) * 4) / 7;
    else              v = 'hF9 + ((c - 329) * 6) / 12;
    return v[7:0];
  endfunction

  function automatic logic advance_beam();
    int unsigned line_dist, r;
    logic vs;
    vs = 1'b0;
    col_img++;
    if (col_img >= LineLen) begin
      col_img = 0;
      line_img++;
      if (line_img >= frame_len()) line_img = 0;
    end
    if (col_img == 271) begin
      if (line_img == frame_len() - 43) irq_img = 1'b1;
      if (regs_img[0][4]) begin
        r = regs_img[10];
        line_dist = (line_img >= 3) ? line_img - 3 : 3 - line_img;
        if (r == 0 || line_dist % (r + 1) == 0) irq_img = 1'b1;
      end
    end
    if (col_img == 279) begin
      if (ntsc_img)
        vs = (height_img == HGT_224) ? line_img == 235 :
             (height_img == HGT_240) ? line_img == 240 : line_img == 219;
      else
        vs = (height_img == HGT_224) ? line_img == 281 :
             (height_img == HGT_240) ? line_img == 297 : line_img == 249;
    end
    if (vs) status_img[7] = 1'b1;
    return vs;
  endfunction

  function automatic void control_byte(logic [7:0] v);
    if (!second_img) begin
      second_img = 1'b1;
      addr_img[7:0] = v;
      return;
    end
    addr_img[13:8] = v[5:0];
    code_img = v[7:6];
    if (code_img == CODE_VRAM_RD) begin
      prefetch_img = vram_img[addr_img];
      addr_img++;
    end else if (code_img == CODE_REG && v[3:0] < NumRegs) begin
      regs_img[v[3:0]] = addr_img[7:0];
      update_height();
    end
    second_img = 1'b0;
  endfunction

  function automatic port_result_t port_step(port_item_t it);
    port_result_t res;
    logic decoded;
    res = '0;
    decoded = it.port >= 8'h80 && it.port <= 8'hBF;
    case (it.mode)
      MODE_TICK: res.fsync = advance_beam();
      MODE_READ: begin
        if (it.port >= 8'h40 && it.port <= 8'h7F) begin
          res.rdata = it.port[0] ? hcount_of() : vcount_of();
        end else if (decoded && it.port[0]) begin
          res.rdata = status_img;
          status_img &= 8'h1F;
        end else if (decoded) begin
          if (code_img == CODE_VRAM_RD) begin
            res.rdata = prefetch_img;
            prefetch_img = vram_img[addr_img];
          end else if (code_img == CODE_CRAM) begin
            res.rdata = cram_img[addr_img[4:0]];
          end else begin
            res.rdata = vram_img[addr_img];
          end
          addr_img++;
        end else begin
          res.bad_port = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (decoded && it.port[0]) begin
          control_byte(it.data);
        end else if (decoded) begin
          if (code_img == CODE_CRAM) begin
            cram_img[addr_img[4:0]] = it.data;
          end else begin
            vram_img[addr_img] = it.data;
            prefetch_img = it.data;
          end
          addr_img++;
        end
      end
      default: begin
        res.irq_seen = irq_img;
        irq_img = 1'b0;
      end
    endcase
    return res;
  endfunction

  // sender
  always @(posedge clk_i) begin
    logic acc;
    int   wnext;
    port_item_t nx;
    if (rst_ni) begin
      acc = s_axis_tvalid && s_axis_tready;
      if (acc) begin
        result_q.push_back(port_step(cur_item));
        n_accepted++;
      end
      if (!s_axis_tvalid || acc) begin
        wnext = acc ? ((item_q.size() != 0) ? item_q[0].gap : 0) : wait_cnt;
        if (wnext != 0) begin
          s_axis_tvalid <= 1'b0;
          wait_cnt <= wnext - 1;
        end else if (item_q.size() != 0) begin
          nx = item_q.pop_front();
          cur_item <= nx;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {nx.data, nx.port};
          s_axis_tuser <= nx.mode;
          wait_cnt <= 0;
        end else begin
          s_axis_tvalid <= 1'b0;
          wait_cnt <= 0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    port_result_t got, want;
    int           snext;
    if (rst_ni) begin
      snext = stall_cnt;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[10:0];
        if (result_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = result_q.pop_front();
          if (got.rdata !== want.rdata || got.fsync !== want.fsync ||
              got.irq_seen !== want.irq_seen || got.bad_port !== want.bad_port ||
              m_axis_tdata[15:11] !== 5'd0) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: want rd=%h fs=%b irq=%b bad=%b got rd=%h fs=%b irq=%b bad=%b",
                       want.rdata, want.fsync, want.irq_seen, want.bad_port,
                       got.rdata, got.fsync, got.irq_seen, got.bad_port);
          end
        end
        snext = calm ? 0 : $urandom_range(0, 19);
      end else if (snext != 0) begin
        snext--;
      end
      stall_cnt <= snext;
      m_axis_tready <= (snext == 0) && !hold;
    end
  end

  task automatic add_item(mode_e m, logic [7:0] p, logic [7:0] d);
    port_item_t it;
    it.mode = m;
    it.port = p;
    it.data = d;
    it.gap = calm ? 0 : $urandom_range(0, 19);
    item_q.push_back(it);
  endtask

  task automatic set_access(logic [13:0] a, logic [1:0] code);
    add_item(MODE_WRITE, PORT_CTRL, a[7:0]);
    add_item(MODE_WRITE, PORT_CTRL, {code, a[13:8]});
  endtask

  task automatic set_reg(logic [3:0] n, logic [7:0] v);
    set_access({6'd0, v}, CODE_REG);
    item_q[item_q.size() - 1].data[3:0] = n;
  endtask

  task automatic run_beam(int n);
    for (int k = 0; k < n; k++) begin
      add_item(MODE_TICK, 8'h00, 8'($urandom));
      if (k % 97 == 96) add_item(MODE_READ, ($urandom_range(0, 1) ? PORT_VCNT : PORT_HCNT), 8'h00);
      if (k % 1031 == 1030) add_item(MODE_POLL, 8'($urandom), 8'($urandom));
      if (k % 3001 == 3000) add_item(MODE_READ, PORT_CTRL, 8'h00);
    end
  endtask

  task automatic drain();
    while (!(item_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0))
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_standard(logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ntsc_img = v;
  endtask

  initial begin
    int unsigned pick;
    logic [13:0] a;
    for (int k = 0; k < VRAM_DEPTH_TB; k++) vram_img[k] = '0;
    for (int k = 0; k < 32; k++) cram_img[k] = '0;
    regs_img = REG_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_standard(1'b1);

    // directed
    add_item(MODE_READ, 8'h00, 8'hFF);
    add_item(MODE_READ, 8'hFF, 8'h00);
    add_item(MODE_READ, 8'h3F, 8'h00);
    add_item(MODE_READ, 8'hC0, 8'h00);
    add_item(MODE_READ, 8'h40, 8'h00);
    add_item(MODE_READ, 8'h7F, 8'h00);
    add_item(MODE_READ, 8'hBF, 8'h00);
    add_item(MODE_WRITE, 8'h00, 8'hFF);
    add_item(MODE_WRITE, 8'hFF, 8'hFF);
    add_item(MODE_WRITE, 8'h80, 8'hA5);
    add_item(MODE_READ, 8'h80, 8'h00);
    set_access(14'h3FFF, CODE_VRAM_WR);
    add_item(MODE_WRITE, PORT_DATA, 8'hFF);
    add_item(MODE_WRITE, PORT_DATA, 8'h00);
    set_access(14'h3FFF, CODE_VRAM_RD);
    add_item(MODE_READ, PORT_DATA, 8'h00);
    add_item(MODE_READ, PORT_DATA, 8'h00);
    set_access(14'h001F, CODE_CRAM);
    add_item(MODE_WRITE, PORT_DATA, 8'h5A);
    add_item(MODE_READ, PORT_CTRL, 8'h00);
    set_reg(4'd15, 8'hFF);
    set_reg(4'd11, 8'h00);
    add_item(MODE_TICK, 8'h00, 8'h00);
    add_item(MODE_POLL, 8'h00, 8'h00);
    drain();

    // NTSC, 224 lines, line interrupt every third line
    calm = 1'b1;
    set_reg(4'd10, 8'd2);
    set_reg(4'd1, 8'h90);
    run_beam(300);
    drain();
    // PAL, 240 lines
    set_standard(1'b0);
    set_reg(4'd1, 8'h88);
    run_beam(60);
    drain();
    // back to NTSC
    set_standard(1'b1);
    run_beam(40);
    drain();

    // random
    for (int ph = 0; ph < 4; ph++) begin
      set_standard(ph[0]);
      if (ph == 1) fork
        begin
          wait (n_accepted > 0 && item_q.size() > 0);
          repeat (100) @(posedge clk_i);
          hold <= 1'b1;
          repeat (400) @(posedge clk_i);
          hold <= 1'b0;
        end
      join_none
      for (int k = 0; k < 90; k++) begin
        if (k % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 9);
        a = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 40));
        case (pick)
          0, 1: begin
            set_access(a, 2'($urandom));
            repeat ($urandom_range(1, 3))
              add_item(mode_e'($urandom_range(0, 1) ? MODE_WRITE : MODE_READ), PORT_DATA,
                       8'($urandom));
          end
          2: set_reg(4'($urandom_range(0, 15)),
                     ($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3))));
          3: set_reg(4'd1, $urandom_range(0, 1) ? 8'h90 : 8'h88);
          4: add_item(MODE_READ, 8'($urandom_range(8'h40, 8'hBF)), 8'($urandom));
          5: add_item(MODE_POLL, 8'($urandom), 8'($urandom));
          6: add_item(mode_e'(2'($urandom)), 8'($urandom), 8'($urandom));
          7: add_item(MODE_WRITE, PORT_CTRL, 8'($urandom));
          default: repeat ($urandom_range(1, 8)) add_item(MODE_TICK, 8'($urandom), 8'($urandom));
        endcase
      end
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

>>> video_port_and_beam_counter.f
+incdir+hw/rtl
hw/rtl/vpbc_pkg.sv
hw/rtl/vpbc_mem.sv
hw/rtl/vpbc_rem.sv
hw/rtl/video_port_and_beam_counter.sv
hw/rtl/vpbc_checker.sv
tb/tb_video_port_and_beam_counter.sv
